// ===== sv/sktim_pkg.sv =====
// package for the sorted key table: depths, widths, status and operation codes
// no dependencies
package sktim_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SRCH_W = CNT_W + 1;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CONSOLIDATE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_MERGED = 3'd1;
  localparam logic [2:0] ST_OVERWRITTEN = 3'd2;
  localparam logic [2:0] ST_FOUND = 3'd3;
  localparam logic [2:0] ST_READ_OK = 3'd4;
  localparam logic [2:0] ST_READ_BAD = 3'd5;
  localparam logic [2:0] ST_FULL = 3'd6;

  typedef struct packed {
    logic load;       // capture input transaction, start search
    logic probe;      // issue memory read at mid
    logic step;       // compare read data, narrow bounds
    logic shift;      // move one entry up during insert
    logic place;      // write new entry at insert point
    logic modify;     // write merged or overwritten value
    logic fin;        // form result
  } sktim_cmd_t;

  typedef struct packed {
    logic is_read;
    logic search_done;
    logic hit;
    logic full;
    logic shift_done;
  } sktim_sts_t;
endpackage

// ===== sv/sorted_key_table_insert_merge_top.sv =====
// top level of the sorted key table: controller plus datapath
// depends on sktim_pkg, sktim_ctrl, sktim_datapath
//
// usage: one input transaction per operation (add, consolidate, update,
// read) on in_valid/in_stall; one result transaction on out_valid/out_stall.
// the table keeps up to 256 (key, value) entries in ascending key order.
// a read fetches the entry at index. a search probes through one memory
// read port, at most 9 probes for 256 entries; after it a hit rewrites the
// matched value, an insert moves entries up one at a time and then writes
// the new entry, and a miss on a full table goes straight to the result.
// one operation is in flight at a time; in_stall is high while it runs and
// while an unaccepted result sits in the output register, so the next
// transaction is taken at the edge where the result is taken.
// reset clears the entry count and the control and holds in_stall high;
// memory contents need none.
// when the receiver stalls, the result holds steady and no new work starts.
module sorted_key_table_insert_merge_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [63:0]        key,
  input  logic signed [31:0] value,
  input  logic               modify_if_found,
  input  logic [7:0]         index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [7:0]         position,
  output logic [63:0]        key_out,
  output logic signed [31:0] value_out,
  output logic [8:0]         entry_count
);
  import sktim_pkg::*;

  sktim_cmd_t cmd;
  sktim_sts_t sts;

  sktim_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  sktim_datapath u_dp (
    .clk, .rst, .cmd, .sts, .operation, .key, .value, .modify_if_found, .index,
    .status, .position, .key_out, .value_out, .entry_count
  );
endmodule

// ===== sv/sktim_datapath.sv =====
// datapath: key/value memories, binary search bounds, insert shifter, result
// depends on sktim_pkg
module sktim_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sktim_pkg::sktim_cmd_t         cmd,
  output sktim_pkg::sktim_sts_t         sts,
  input  logic [1:0]                    operation,
  input  logic [63:0]                   key,
  input  logic signed [31:0]            value,
  input  logic                          modify_if_found,
  input  logic [7:0]                    index,
  output logic [2:0]                    status,
  output logic [7:0]                    position,
  output logic [63:0]                   key_out,
  output logic signed [31:0]            value_out,
  output logic [8:0]                    entry_count
);
  import sktim_pkg::*;

  logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [31:0]         val_mem [TABLE_DEPTH];

  logic [1:0]          op_r;
  logic [63:0]         key_r;
  logic [31:0]         val_r;
  logic                mod_r;
  logic [7:0]          idx_r;
  logic [CNT_W-1:0]    used;
  logic signed [SRCH_W-1:0] low, high;
  logic [IDX_W-1:0]    mid;
  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_val;
  logic                hit;
  logic                placed;
  logic [CNT_W-1:0]    sh;        // destination of next shift
  logic [KEY_BITS-1:0] mkey;

  logic signed [SRCH_W-1:0] sum_lh;
  logic [IDX_W-1:0]    rd_addr;
  logic                do_wr;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [31:0]         wr_val;
  logic                wr_key_en;

  assign mkey = key_r[KEY_BITS-1:0];
  assign sum_lh = (low + high) >>> 1;
  assign mid = sum_lh[IDX_W-1:0];

  // read address: probe mid, read index, or source entry below the shift destination
  always_comb begin
    if (cmd.shift) begin
      rd_addr = IDX_W'(sh - 2'd2);
    end else if (cmd.probe) begin
      rd_addr = mid;
    end else if (op_r == OP_READ) begin
      rd_addr = idx_r;
    end else begin
      rd_addr = IDX_W'(sh - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  always_comb begin
    do_wr = 1'b0;
    wr_addr = mid;
    wr_key = rd_key;
    wr_val = rd_val;
    wr_key_en = 1'b1;
    if (cmd.shift) begin
      do_wr = 1'b1;
      wr_addr = IDX_W'(sh);
    end else if (cmd.place) begin
      do_wr = 1'b1;
      wr_addr = IDX_W'(low);
      wr_key = mkey;
      wr_val = val_r;
    end else if (cmd.modify) begin
      do_wr = 1'b1;
      wr_key_en = 1'b0;
      if (op_r == OP_CONSOLIDATE) wr_val = rd_val + val_r;
      else if (mod_r) wr_val = val_r;
      else wr_val = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      val_mem[wr_addr] <= wr_val;
      if (wr_key_en) key_mem[wr_addr] <= wr_key;
    end
  end

  // sh runs from used down to low+1; its source sh-1 is read in the previous cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.place) begin
      used <= used + 1'b1;
    end
    if (cmd.load) begin
      op_r <= operation;
      key_r <= 64'(key[KEY_BITS-1:0]);
      val_r <= value;
      mod_r <= modify_if_found;
      idx_r <= index;
      low <= '0;
      high <= SRCH_W'(used) - 1'b1;
      hit <= 1'b0;
      placed <= 1'b0;
      sh <= used;
    end
    if (cmd.step) begin
      if (mkey < rd_key) begin
        high <= sum_lh - 1'b1;
      end else if (mkey > rd_key || op_r == OP_ADD) begin
        low <= sum_lh + 1'b1;
      end else begin
        hit <= 1'b1;
      end
    end
    if (cmd.shift) sh <= sh - 1'b1;
    if (cmd.place) placed <= 1'b1;
    // keep the stored value after a hit for the result
    if (cmd.modify) val_r <= wr_val;
    if (cmd.fin) begin
      entry_count <= 9'(used);
      if (op_r == OP_READ) begin
        position <= idx_r;
        if (CNT_W'(idx_r) < used) begin
          status <= ST_READ_OK;
          key_out <= 64'(rd_key);
          value_out <= rd_val;
        end else begin
          status <= ST_READ_BAD;
          key_out <= '0;
          value_out <= '1;
        end
      end else begin
        key_out <= key_r;
        if (hit) begin
          position <= 8'(mid);
          value_out <= val_r;
          if (op_r == OP_CONSOLIDATE) status <= ST_MERGED;
          else if (mod_r) status <= ST_OVERWRITTEN;
          else status <= ST_FOUND;
        end else if (placed) begin
          status <= ST_INSERTED;
          position <= 8'(low);
          value_out <= val_r;
        end else begin
          status <= ST_FULL;
          position <= '0;
          value_out <= '0;
        end
      end
    end
  end

  // fin of a read is issued with the read address at idx
  assign sts.is_read = (op_r == OP_READ);
  assign sts.search_done = hit || (low > high);
  assign sts.hit = hit;
  assign sts.full = used >= CNT_W'(TABLE_DEPTH);
  assign sts.shift_done = (sh == CNT_W'(low));
endmodule

// ===== sv/sktim_ctrl.sv =====
// controller: sequences search, shift, write and result handoff
// depends on sktim_pkg
module sktim_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  sktim_pkg::sktim_sts_t sts,
  output sktim_pkg::sktim_cmd_t cmd
);
  import sktim_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;

  logic [2:0] state, state_next;
  logic out_hold;

  // output register holds one result; new work waits until it is taken
  assign out_hold = out_valid && out_stall;
  assign in_stall = rst || (state != S_IDLE) || out_hold;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.is_read) state_next = S_RDWAIT;
        else if (sts.search_done) begin
          if (sts.hit) begin
            // fetch the matched value for the write
            cmd.probe = 1'b1;
            state_next = S_WRITE;
          end
          else if (sts.full) state_next = S_FIN;
          else state_next = S_SHIFT;
        end else begin
          cmd.probe = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step = 1'b1;
        state_next = S_PROBE;
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.place = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.modify = 1'b1;
        state_next = S_FIN;
      end
      S_RDWAIT: state_next = S_FIN;
      S_FIN: begin
        if (!out_hold) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule

// ===== sv/sktim_checker.sv =====
// port-level checks for the sorted key table
// depends on sktim_pkg and sorted_key_table_insert_merge_top ports only
module sktim_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [8:0]  entry_count,
  input logic [31:0] value_out,
  input logic [63:0] key_out
);
  import sktim_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out))
    else $error("result changed while stalled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 9'(TABLE_DEPTH)) else $error("entry count too large");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_READ_BAD |-> value_out == '1 && key_out == '0)
    else $error("bad read payload");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall && in_valid |=> in_stall) else $error("accepted while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL) else $error("invalid status");
endmodule

bind sorted_key_table_insert_merge_top sktim_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status,
  .entry_count, .value_out, .key_out
);

// ===== verif/tb_top.sv =====
// testbench for sorted_key_table_insert_merge_top: directed and random table operations
// checked against a behavioral predictor of the sorted table; depends on sktim_pkg
module tb_top;
  import sktim_pkg::*;

  typedef struct {
    logic [2:0]         status;
    logic [7:0]         position;
    logic [63:0]        key_out;
    logic signed [31:0] value_out;
    logic [8:0]         entry_count;
  } table_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] operation;
  logic [63:0] key;
  logic signed [31:0] value;
  logic modify_if_found;
  logic [7:0] index;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] position;
  logic [63:0] key_out;
  logic signed [31:0] value_out;
  logic [8:0] entry_count;

  sorted_key_table_insert_merge_top dut (.*);

  // predicted table contents
  logic [63:0] tbl_key [TABLE_DEPTH];
  logic [31:0] tbl_val [TABLE_DEPTH];
  int tbl_cnt;

  table_result_t pending_results[$];
  logic [63:0] key_pool[$];
  int errors = 0;
  bit no_idle;
  bit hold_req;
  bit hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predicts one accepted transaction and queues its result
  function automatic void predict_table_op(logic [1:0] op, logic [63:0] k, logic [31:0] v,
                                           logic m, logic [7:0] idx);
    table_result_t r;
    int lo;
    int hi;
    int mid;
    int at;
    bit hit;
    r.status = ST_FULL;
    r.position = 0;
    r.key_out = k;
    r.value_out = 0;
    hit = 0;
    at = 0;
    if (op == OP_READ) begin
      r.position = idx;
      if (idx < tbl_cnt) begin
        r.status = ST_READ_OK;
        r.key_out = tbl_key[idx];
        r.value_out = tbl_val[idx];
      end else begin
        r.status = ST_READ_BAD;
        r.key_out = 0;
        r.value_out = -1;
      end
    end else begin
      lo = 0;
      hi = tbl_cnt - 1;
      while (lo <= hi && !hit) begin
        mid = (lo + hi) / 2;
        if (k < tbl_key[mid]) hi = mid - 1;
        else if (k > tbl_key[mid]) lo = mid + 1;
        else if (op != OP_ADD) begin
          hit = 1;
          at = mid;
        end else lo = mid + 1;
      end
      if (!hit) at = lo;
      if (hit && op == OP_CONSOLIDATE) begin
        tbl_val[at] = tbl_val[at] + v;
        r.status = ST_MERGED;
        r.position = at[7:0];
        r.value_out = tbl_val[at];
      end else if (hit) begin
        if (m) begin
          tbl_val[at] = v;
          r.status = ST_OVERWRITTEN;
        end else r.status = ST_FOUND;
        r.position = at[7:0];
        r.value_out = tbl_val[at];
      end else if (tbl_cnt < TABLE_DEPTH) begin
        for (int i = tbl_cnt; i > at; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_val[i] = tbl_val[i-1];
        end
        tbl_key[at] = k;
        tbl_val[at] = v;
        tbl_cnt++;
        r.status = ST_INSERTED;
        r.position = at[7:0];
        r.value_out = v;
      end
    end
    r.entry_count = tbl_cnt[8:0];
    pending_results.push_back(r);
  endfunction

  task automatic send_op(logic [1:0] op, logic [63:0] k, logic [31:0] v, logic m,
                         logic [7:0] idx);
    if (!no_idle) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    operation <= op;
    key <= k;
    value <= v;
    modify_if_found <= m;
    index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table_op(op, k, v, m, idx);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(99) < 70)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic test_empty_table();
    send_op(OP_READ, 0, 0, 0, 0);
    send_op(OP_READ, '1, '1, 1, 8'hff);
    send_op(OP_CONSOLIDATE, 64'h4142_4300_0000_0000, 32'sd5, 0, 0);
    send_op(OP_UPDATE, 64'h10, 32'sd7, 1, 0);
  endtask

  task automatic test_directed_ops();
    send_op(OP_ADD, 0, 32'h8000_0000, 0, 0);
    send_op(OP_ADD, '1, 32'h7fff_ffff, 0, 0);
    send_op(OP_ADD, 64'h10, 32'sd1, 0, 0);
    send_op(OP_ADD, 64'h10, 32'sd2, 0, 0);
    send_op(OP_CONSOLIDATE, 64'h10, 32'sd3, 0, 0);
    // merge wraps at 32 bits
    send_op(OP_CONSOLIDATE, '1, 32'sd1, 0, 0);
    send_op(OP_CONSOLIDATE, 0, 32'hffff_ffff, 0, 0);
    send_op(OP_UPDATE, 64'h4142_4300_0000_0000, 32'sd99, 1, 0);
    send_op(OP_UPDATE, 64'h4142_4300_0000_0000, 32'sd77, 0, 0);
    send_op(OP_UPDATE, 64'h20, -32'sd4, 0, 0);
    for (int i = 0; i < 10; i++) send_op(OP_READ, 0, 0, 0, i[7:0]);
    send_op(OP_READ, 0, 0, 0, 8'h80);
    key_pool.push_back(0);
    key_pool.push_back('1);
    key_pool.push_back(64'h10);
    wait_drained();
  endtask

  task automatic test_hold_off();
    wait_drained();
    hold_req = ~hold_req;
    no_idle = 1;
    for (int i = 0; i < 6; i++)
      send_op(i[0] ? OP_READ : OP_CONSOLIDATE, pick_key(), $urandom, 0, 8'($urandom));
    no_idle = 0;
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3 && i < count / 3 + 150);
      op = 2'($urandom_range(3));
      k = pick_key();
      if (key_pool.size() < 48 && $urandom_range(99) < 30) key_pool.push_back(k);
      send_op(op, k, $urandom, 1'($urandom_range(1)), $urandom_range(99) < 70 ?
              8'($urandom_range(tbl_cnt)) : 8'($urandom));
    end
    no_idle = 0;
    wait_drained();
  endtask

  // fill to capacity, then hit and miss on a full table
  task automatic test_full_table();
    while (tbl_cnt < TABLE_DEPTH) send_op(OP_ADD, {$urandom, $urandom}, $urandom, 0, 0);
    send_op(OP_ADD, pick_key(), $urandom, 0, 0);
    send_op(OP_CONSOLIDATE, {$urandom, $urandom}, $urandom, 0, 0);
    send_op(OP_CONSOLIDATE, key_pool[0], $urandom, 0, 0);
    send_op(OP_UPDATE, key_pool[1], $urandom, 1, 0);
    send_op(OP_UPDATE, {$urandom, $urandom}, $urandom, 1, 0);
    send_op(OP_READ, 0, 0, 0, 8'hff);
    send_op(OP_READ, 0, 0, 0, 0);
    wait_drained();
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 24);
  end

  always @(posedge clk) begin
    table_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d", $time, status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (position !== e.position) begin
          $display("%0t: position exp %0d got %0d", $time, e.position, position);
          errors++;
        end
        if (key_out !== e.key_out) begin
          $display("%0t: key_out exp %h got %h", $time, e.key_out, key_out);
          errors++;
        end
        if (value_out !== e.value_out) begin
          $display("%0t: value_out exp %0d got %0d", $time, e.value_out, value_out);
          errors++;
        end
        if (entry_count !== e.entry_count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count, entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1;
    in_valid = 0;
    operation = OP_READ;
    key = 0;
    value = 0;
    modify_if_found = 0;
    index = 0;
    no_idle = 0;
    hold_req = 0;
    tbl_cnt = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    test_empty_table();
    test_directed_ops();
    test_hold_off();
    test_random(1750);
    test_hold_off();
    test_full_table();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("CHECK OK");
    else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
